[hdl/matrix_vector_multiply_unit_assert.svh]
// assertion macros used by the checker file
`ifndef MATRIX_VECTOR_MULTIPLY_UNIT_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define MVMU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MVMU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mvmu_pkg.sv]
package mvmu_pkg;

  localparam int VALUE_W           = 32;
  localparam int IDX_W             = 3;
  localparam int REQ_W             = 2;
  localparam int ORDER_W           = 4;
  localparam int CFG_ADDR_W        = 3;
  localparam int CFG_DATA_W        = 32;
  localparam int DEFAULT_MAX_ORDER = 8;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd3;

  // register indexes
  localparam int REG_ORDER_IN_USE = 0;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET    = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_VECTOR = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_MAC,
    ST_ROW_OUT,
    ST_ECHO_RD,
    ST_ECHO_OUT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic mat_set;
    logic add_rd;
    logic add_wr;
    logic mac_rd;
    logic mac_first;
    logic mac_last;
    logic vec_wr;
    logic vec_rd;
    logic out_row;
    logic out_echo;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic kind_set;
    logic kind_add;
    logic kind_vec;
    logic idx_ok;
    logic item_last;
    logic sum_ready;
    logic out_free;
  } status_t;

endpackage

[hdl/mvmu_req_if.sv]
interface mvmu_req_if;
  import mvmu_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic [IDX_W-1:0]          row_index;
  logic [IDX_W-1:0]          col_index;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, req_type, row_index, col_index, value, last, input ready);
  modport sink   (input valid, req_type, row_index, col_index, value, last, output ready);
endinterface

[hdl/mvmu_res_if.sv]
interface mvmu_res_if;
  import mvmu_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] result_value;
  logic [IDX_W-1:0]          result_index;
  logic                      length_mismatch;
  logic                      last_result;

  modport source (output valid, result_value, result_index, length_mismatch, last_result,
                  input ready);
  modport sink   (input valid, result_value, result_index, length_mismatch, last_result,
                  output ready);
endinterface

[hdl/mvmu_ctrl.sv]
module mvmu_ctrl #(
  parameter int MAX_ORDER = mvmu_pkg::DEFAULT_MAX_ORDER,
  localparam int IW = $clog2(MAX_ORDER),
  localparam int NW = $clog2(MAX_ORDER + 1),
  localparam int CW = $clog2(MAX_ORDER + 2)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [NW-1:0]     order_eff,
  input  mvmu_pkg::status_t status,
  output mvmu_pkg::cmd_t    cmd,
  output logic [IW-1:0]     row_ptr,
  output logic [IW-1:0]     col_ptr,
  output logic [IW-1:0]     vec_wr_addr
);
  import mvmu_pkg::*;

  state_t        state, state_next;
  logic [CW-1:0] vcount, vcount_next, vcount_inc;
  logic [IW-1:0] row_ptr_next, col_ptr_next;
  logic [NW-1:0] echo_len, echo_len_next;
  logic          accept;
  logic          col_last, row_last, echo_last, len_match;

  assign accept      = status.in_valid && (state == ST_IDLE);
  assign vcount_inc  = (vcount < CW'(MAX_ORDER + 1)) ? vcount + CW'(1) : vcount;
  assign len_match   = (vcount_inc == CW'(order_eff));
  assign col_last    = ((NW'(col_ptr) + NW'(1)) == order_eff);
  assign row_last    = ((NW'(row_ptr) + NW'(1)) == order_eff);
  assign echo_last   = ((NW'(row_ptr) + NW'(1)) == echo_len);
  assign vec_wr_addr = IW'(vcount);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      vcount   <= '0;
      row_ptr  <= '0;
      col_ptr  <= '0;
      echo_len <= '0;
    end else begin
      state    <= state_next;
      vcount   <= vcount_next;
      row_ptr  <= row_ptr_next;
      col_ptr  <= col_ptr_next;
      echo_len <= echo_len_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (status.kind_add && status.idx_ok) begin
            state_next = ST_ADD_WR;
          end else if (status.kind_vec && status.item_last) begin
            state_next = len_match ? ST_MAC : ST_ECHO_RD;
          end
        end
      end
      ST_ADD_WR: begin
        state_next = ST_IDLE;
      end
      ST_MAC: begin
        if (col_last) state_next = ST_ROW_OUT;
      end
      ST_ROW_OUT: begin
        if (status.sum_ready && status.out_free) state_next = row_last ? ST_IDLE : ST_MAC;
      end
      ST_ECHO_RD: begin
        state_next = ST_ECHO_OUT;
      end
      ST_ECHO_OUT: begin
        if (status.out_free) state_next = echo_last ? ST_IDLE : ST_ECHO_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    vcount_next   = vcount;
    row_ptr_next  = row_ptr;
    col_ptr_next  = col_ptr;
    echo_len_next = echo_len;
    cmd.in_ready  = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.mat_set = status.kind_set && status.idx_ok;
          cmd.add_rd  = status.kind_add && status.idx_ok;
          if (status.kind_vec) begin
            // entries past the buffer are counted but not stored
            cmd.vec_wr  = (vcount < CW'(MAX_ORDER));
            vcount_next = status.item_last ? '0 : vcount_inc;
            if (status.item_last) begin
              row_ptr_next  = '0;
              col_ptr_next  = '0;
              echo_len_next = (vcount_inc > CW'(MAX_ORDER)) ? NW'(MAX_ORDER) : NW'(vcount_inc);
            end
          end
        end
      end
      ST_ADD_WR: begin
        cmd.add_wr = 1'b1;
      end
      ST_MAC: begin
        cmd.mac_rd    = 1'b1;
        cmd.mac_first = (col_ptr == '0);
        cmd.mac_last  = col_last;
        col_ptr_next  = col_last ? '0 : col_ptr + IW'(1);
      end
      ST_ROW_OUT: begin
        if (status.sum_ready && status.out_free) begin
          cmd.out_row  = 1'b1;
          cmd.out_last = row_last;
          row_ptr_next = row_ptr + IW'(1);
        end
      end
      ST_ECHO_RD: begin
        cmd.vec_rd = 1'b1;
      end
      ST_ECHO_OUT: begin
        if (status.out_free) begin
          cmd.out_echo = 1'b1;
          cmd.out_last = echo_last;
          row_ptr_next = row_ptr + IW'(1);
        end
      end
      default: begin
        cmd.in_ready = 1'b0;
      end
    endcase
  end

endmodule

[hdl/mvmu_datapath.sv]
module mvmu_datapath #(
  parameter int MAX_ORDER = mvmu_pkg::DEFAULT_MAX_ORDER,
  localparam int IW = $clog2(MAX_ORDER),
  localparam int NW = $clog2(MAX_ORDER + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [NW-1:0]     order_eff,
  mvmu_req_if.sink          request,
  mvmu_res_if.source        result,
  input  mvmu_pkg::cmd_t    cmd,
  output mvmu_pkg::status_t status,
  input  logic [IW-1:0]     row_ptr,
  input  logic [IW-1:0]     col_ptr,
  input  logic [IW-1:0]     vec_wr_addr
);
  import mvmu_pkg::*;

  localparam int AW     = 2 * VALUE_W + IW;
  localparam int DEPTH  = 1 << (2 * IW);
  localparam int FRAC_W = 16;
  localparam logic signed [VALUE_W-1:0] Q_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] Q_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};

  // matrix store, row-major with power-of-two stride
  logic signed [VALUE_W-1:0] mat_mem [DEPTH];
  logic [DEPTH-1:0]          mat_valid;
  logic signed [VALUE_W-1:0] vec_mem [MAX_ORDER];

  logic [2*IW-1:0]           in_addr, mac_addr, mat_rd_addr, add_addr;
  logic [IW-1:0]             vec_rd_addr;
  logic signed [VALUE_W-1:0] mat_raw, mat_rdata, vec_rdata, add_value, add_sat, row_sat;
  logic                      mat_rd_valid;
  logic signed [VALUE_W:0]   add_sum;

  logic                        s1_valid, s1_first, s1_last;
  logic                        s2_valid, s2_first, s2_last;
  logic signed [2*VALUE_W-1:0] prod;
  logic signed [AW-1:0]        acc, acc_shift;
  logic                        sum_ready, acc_ovf;

  logic                      out_valid, out_mismatch, out_last;
  logic signed [VALUE_W-1:0] out_value;
  logic [IDX_W-1:0]          out_index;

  assign in_addr     = {IW'(request.row_index), IW'(request.col_index)};
  assign mac_addr    = {row_ptr, col_ptr};
  assign mat_rd_addr = cmd.add_rd ? in_addr : mac_addr;
  assign vec_rd_addr = cmd.mac_rd ? col_ptr : row_ptr;

  always_ff @(posedge clk) begin
    if (cmd.mat_set) begin
      mat_mem[in_addr] <= request.value;
    end else if (cmd.add_wr) begin
      mat_mem[add_addr] <= add_sat;
    end
    if (cmd.add_rd || cmd.mac_rd) begin
      mat_raw <= mat_mem[mat_rd_addr];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      mat_valid    <= '0;
      mat_rd_valid <= 1'b0;
    end else begin
      if (cmd.mat_set) begin
        mat_valid[in_addr] <= 1'b1;
      end else if (cmd.add_wr) begin
        mat_valid[add_addr] <= 1'b1;
      end
      if (cmd.add_rd || cmd.mac_rd) begin
        mat_rd_valid <= mat_valid[mat_rd_addr];
      end
    end
  end

  assign mat_rdata = mat_rd_valid ? mat_raw : '0;

  always_ff @(posedge clk) begin
    if (cmd.vec_wr) begin
      vec_mem[vec_wr_addr] <= request.value;
    end
    if (cmd.vec_rd || cmd.mac_rd) begin
      vec_rdata <= vec_mem[vec_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_rd) begin
      add_addr  <= in_addr;
      add_value <= request.value;
    end
  end

  assign add_sum = {mat_rdata[VALUE_W-1], mat_rdata} + {add_value[VALUE_W-1], add_value};
  always_comb begin
    if (add_sum[VALUE_W] != add_sum[VALUE_W-1]) begin
      add_sat = add_sum[VALUE_W] ? Q_MIN : Q_MAX;
    end else begin
      add_sat = add_sum[VALUE_W-1:0];
    end
  end

  // multiply-accumulate pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      sum_ready <= 1'b0;
    end else begin
      s1_valid <= cmd.mac_rd;
      s2_valid <= s1_valid;
      if (s2_valid && s2_last) begin
        sum_ready <= 1'b1;
      end else if (cmd.out_row) begin
        sum_ready <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= cmd.mac_first;
    s1_last  <= cmd.mac_last;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    prod     <= mat_rdata * vec_rdata;
    if (s2_valid) begin
      acc <= s2_first ? AW'(prod) : acc + AW'(prod);
    end
  end

  // floor to q16.16, then clamp to 32 bits
  assign acc_shift = acc >>> FRAC_W;
  assign acc_ovf   = !((&acc_shift[AW-1:VALUE_W-1]) || !(|acc_shift[AW-1:VALUE_W-1]));
  always_comb begin
    if (acc_ovf) begin
      row_sat = acc_shift[AW-1] ? Q_MIN : Q_MAX;
    end else begin
      row_sat = acc_shift[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_row || cmd.out_echo) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_row || cmd.out_echo) begin
      out_value    <= cmd.out_echo ? vec_rdata : row_sat;
      out_index    <= IDX_W'(row_ptr);
      out_mismatch <= cmd.out_echo;
      out_last     <= cmd.out_last;
    end
  end

  assign result.valid           = out_valid;
  assign result.result_value    = out_value;
  assign result.result_index    = out_index;
  assign result.length_mismatch = out_mismatch;
  assign result.last_result     = out_last;
  assign request.ready          = cmd.in_ready;

  always_comb begin
    status          = '0;
    status.in_valid = request.valid;
    case (req_type_t'(request.req_type))
      REQ_SET:    status.kind_set = 1'b1;
      REQ_ADD:    status.kind_add = 1'b1;
      REQ_VECTOR: status.kind_vec = 1'b1;
      default:    status.kind_set = 1'b0;
    endcase
    status.idx_ok    = (32'(request.row_index) < 32'(order_eff)) &&
                       (32'(request.col_index) < 32'(order_eff));
    status.item_last = request.last;
    status.sum_ready = sum_ready;
    status.out_free  = !out_valid || result.ready;
  end

endmodule

[hdl/matrix_vector_multiply_unit.sv]
// matrix-vector multiply unit, q16.16 signed
// request channel: one transaction sets a matrix element, adds to one
// (saturating), or brings one vector element; set/add with an index at or
// above the order in use are dropped. order_in_use lives at byte address 0
// of the apb port and is capped at MAX_ORDER.
// result channel: on the vector element marked last the block emits n row
// sums (n = order in use), indices 0..n-1, last_result on the final one.
// if the vector length differs from n the stored vector is echoed instead
// with length_mismatch set.
// element loads are taken straight from idle; an add reads the entry,
// then writes the saturated sum back. each row of a product run issues
// n reads into a read/multiply/accumulate pipeline, shared by all rows,
// and waits for it to drain. an echo reads each stored element, then
// sends it. new requests are taken only between runs.
// the result register holds its transaction while the receiver stalls and
// the run pauses behind it.
// reset clears the matrix (per-entry valid flags, no clearing pass), the
// vector count and the order register (back to 3); the vector buffer is
// left as is.
module matrix_vector_multiply_unit #(
  parameter int MAX_ORDER = mvmu_pkg::DEFAULT_MAX_ORDER
) (
  input  logic                            clk,
  input  logic                            rst,
  mvmu_req_if.sink                        request,
  mvmu_res_if.source                      result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mvmu_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mvmu_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mvmu_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import mvmu_pkg::*;

  localparam int IW = $clog2(MAX_ORDER);
  localparam int NW = $clog2(MAX_ORDER + 1);

  logic [ORDER_W-1:0] order_in_use;
  logic [NW-1:0]      order_eff;
  logic               cfg_sel;
  cmd_t               cmd;
  status_t            status;
  logic [IW-1:0]      row_ptr, col_ptr, vec_wr_addr;

  assign cfg_sel = (paddr[CFG_ADDR_W-1:2] == (CFG_ADDR_W - 2)'(REG_ORDER_IN_USE));
  assign pready  = 1'b1;
  assign prdata  = cfg_sel ? CFG_DATA_W'(order_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_in_use <= ORDER_RESET;
    end else if (psel && penable && pwrite && cfg_sel) begin
      order_in_use <= pwdata[ORDER_W-1:0];
    end
  end

  assign order_eff = (32'(order_in_use) > MAX_ORDER) ? NW'(MAX_ORDER) : NW'(order_in_use);

  mvmu_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .order_eff   (order_eff),
    .status      (status),
    .cmd         (cmd),
    .row_ptr     (row_ptr),
    .col_ptr     (col_ptr),
    .vec_wr_addr (vec_wr_addr)
  );

  mvmu_datapath #(.MAX_ORDER(MAX_ORDER)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .order_eff   (order_eff),
    .request     (request),
    .result      (result),
    .cmd         (cmd),
    .status      (status),
    .row_ptr     (row_ptr),
    .col_ptr     (col_ptr),
    .vec_wr_addr (vec_wr_addr)
  );

endmodule

[hdl/mvmu_checker.sv]
`include "matrix_vector_multiply_unit_assert.svh"

module mvmu_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic [mvmu_pkg::REQ_W-1:0]         req_type,
  input logic                               req_last,
  input logic                               res_valid,
  input logic                               res_ready,
  input logic signed [mvmu_pkg::VALUE_W-1:0] res_value,
  input logic [mvmu_pkg::IDX_W-1:0]         res_index,
  input logic                               res_mismatch,
  input logic                               res_last
);
  import mvmu_pkg::*;

  logic res_stall, res_done, vec_end;

  assign res_stall = res_valid && !res_ready;
  assign res_done  = res_valid && res_ready;
  assign vec_end   = req_valid && req_ready && (req_type == REQ_VECTOR) && req_last;

  `MVMU_ASSERT_NEXT(a_res_hold, res_stall, res_valid, "result dropped while stalled")
  `MVMU_ASSERT_NEXT(a_res_stable, res_stall,
    $stable(res_value) && $stable(res_index) && $stable(res_mismatch) && $stable(res_last),
    "result payload changed while stalled")
  // the end of a vector always starts a result run
  `MVMU_ASSERT_NEXT(a_run_starts, vec_end, !req_ready, "no result run after last element")
  // no request is taken in the middle of a run
  `MVMU_ASSERT_NOW(a_run_busy, res_done && !res_last, !req_ready,
    "request taken during result run")

endmodule

bind matrix_vector_multiply_unit mvmu_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (request.valid),
  .req_ready    (request.ready),
  .req_type     (request.req_type),
  .req_last     (request.last),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_value    (result.result_value),
  .res_index    (result.result_index),
  .res_mismatch (result.length_mismatch),
  .res_last     (result.last_result)
);
